>>> rtl/core/mi3_pkg.sv
package mi3_pkg;

	localparam int DATA_W   = 32;
	localparam int PROD_W   = 2 * DATA_W;
	localparam int COF_W    = 2 * DATA_W + 1;
	localparam int DET_W    = 3 * DATA_W + 3;
	localparam int REM_W    = DET_W + DATA_W;
	localparam int NUM_ELEM = 9;

	typedef logic signed [DATA_W-1:0] elem_t;
	typedef logic signed [COF_W-1:0]  cof_t;
	typedef logic signed [DET_W-1:0]  det_t;
	typedef logic [REM_W-1:0]         rem_t;
	typedef logic [DATA_W-1:0]        quo_t;
	typedef logic [3:0]               idx_t;

	typedef struct packed {
		elem_t m00;
		elem_t m01;
		elem_t m02;
		elem_t m10;
		elem_t m11;
		elem_t m12;
		elem_t m20;
		elem_t m21;
		elem_t m22;
	} mat_in_t;

	typedef struct packed {
		elem_t r00;
		elem_t r01;
		elem_t r02;
		elem_t r10;
		elem_t r11;
		elem_t r12;
		elem_t r20;
		elem_t r21;
		elem_t r22;
		logic  singular;
		logic  saturated;
	} inv_out_t;

	typedef struct packed {
		logic [NUM_ELEM-1:0] neg;
		logic                singular;
	} sign_t;

	typedef struct packed {
		sign_t               sgn;
		logic [NUM_ELEM-1:0] big;
	} div_ctl_t;

	// adjugate entry i = a[x]*a[y] - a[z]*a[w]
	localparam idx_t COF_IDX [NUM_ELEM][4] = '{
		'{4'd4, 4'd8, 4'd7, 4'd5}, '{4'd2, 4'd7, 4'd8, 4'd1}, '{4'd1, 4'd5, 4'd4, 4'd2},
		'{4'd5, 4'd6, 4'd8, 4'd3}, '{4'd0, 4'd8, 4'd6, 4'd2}, '{4'd2, 4'd3, 4'd5, 4'd0},
		'{4'd3, 4'd7, 4'd6, 4'd4}, '{4'd1, 4'd6, 4'd7, 4'd0}, '{4'd0, 4'd4, 4'd3, 4'd1}
	};

endpackage

>>> rtl/core/mi3_adj.sv
module mi3_adj (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld,
	input  mi3_pkg::mat_in_t mat,
	output logic            vld_s2,
	output mi3_pkg::cof_t   cof_s2 [mi3_pkg::NUM_ELEM],
	output mi3_pkg::elem_t  row0_s2 [3]
);
	import mi3_pkg::*;

	elem_t a [NUM_ELEM];
	logic signed [PROD_W-1:0] pa_s1 [NUM_ELEM];
	logic signed [PROD_W-1:0] pb_s1 [NUM_ELEM];
	elem_t row0_s1 [3];
	logic  vld_s1;

	assign a[0] = mat.m00;
	assign a[1] = mat.m01;
	assign a[2] = mat.m02;
	assign a[3] = mat.m10;
	assign a[4] = mat.m11;
	assign a[5] = mat.m12;
	assign a[6] = mat.m20;
	assign a[7] = mat.m21;
	assign a[8] = mat.m22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_ELEM; i++) begin
			pa_s1[i]  <= PROD_W'(a[COF_IDX[i][0]]) * PROD_W'(a[COF_IDX[i][1]]);
			pb_s1[i]  <= PROD_W'(a[COF_IDX[i][2]]) * PROD_W'(a[COF_IDX[i][3]]);
			cof_s2[i] <= COF_W'(pa_s1[i]) - COF_W'(pb_s1[i]);
		end
		for (int j = 0; j < 3; j++) begin
			row0_s1[j] <= a[j];
			row0_s2[j] <= row0_s1[j];
		end
	end

endmodule

>>> rtl/core/mi3_det.sv
module mi3_det #(
	parameter int FRAC_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld,
	input  mi3_pkg::cof_t   cof [mi3_pkg::NUM_ELEM],
	input  mi3_pkg::elem_t  row0 [3],
	output logic            vld_s4,
	output mi3_pkg::sign_t  sgn_s4,
	output mi3_pkg::rem_t   num_s4 [mi3_pkg::NUM_ELEM],
	output logic [mi3_pkg::DET_W-1:0] den_s4
);
	import mi3_pkg::*;

	localparam int PP_W = 2 * DATA_W + 1;

	logic signed [PP_W-1:0] plo_s1 [3];
	logic signed [PP_W-1:0] phi_s1 [3];
	det_t pj_s2 [3];
	det_t det_s3;
	cof_t cof_s1 [NUM_ELEM];
	cof_t cof_s2 [NUM_ELEM];
	cof_t cof_s3 [NUM_ELEM];
	logic vld_s1, vld_s2, vld_s3;
	logic [COF_W-1:0] cof_abs [NUM_ELEM];

	always_comb begin
		for (int i = 0; i < NUM_ELEM; i++) begin
			cof_abs[i] = cof_s3[i][COF_W-1] ? -cof_s3[i] : cof_s3[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		// first-row expansion, each cofactor split into a low and a high half
		for (int j = 0; j < 3; j++) begin
			plo_s1[j] <= PP_W'(row0[j]) * PP_W'($signed({1'b0, cof[3*j][DATA_W-1:0]}));
			phi_s1[j] <= PP_W'(row0[j]) * PP_W'($signed(cof[3*j][COF_W-1:DATA_W]));
			pj_s2[j]  <= (DET_W'(phi_s1[j]) << DATA_W) + DET_W'(plo_s1[j]);
		end
		det_s3 <= pj_s2[0] + pj_s2[1] + pj_s2[2];
		den_s4 <= det_s3[DET_W-1] ? -det_s3 : det_s3;
		sgn_s4.singular <= (det_s3 == '0);
		for (int i = 0; i < NUM_ELEM; i++) begin
			cof_s1[i] <= cof[i];
			cof_s2[i] <= cof_s1[i];
			cof_s3[i] <= cof_s2[i];
			num_s4[i] <= REM_W'(cof_abs[i]) << (2 * FRAC_BITS);
			sgn_s4.neg[i] <= cof_s3[i][COF_W-1] ^ det_s3[DET_W-1];
		end
	end

endmodule

>>> rtl/core/mi3_div_step.sv
module mi3_div_step #(
	parameter int BIT = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld,
	input  mi3_pkg::div_ctl_t ctl,
	input  logic [mi3_pkg::DET_W-1:0] den,
	input  mi3_pkg::rem_t     rem [mi3_pkg::NUM_ELEM],
	input  mi3_pkg::quo_t     quo [mi3_pkg::NUM_ELEM],
	output logic              vld_s1,
	output mi3_pkg::div_ctl_t ctl_s1,
	output logic [mi3_pkg::DET_W-1:0] den_s1,
	output mi3_pkg::rem_t     rem_s1 [mi3_pkg::NUM_ELEM],
	output mi3_pkg::quo_t     quo_s1 [mi3_pkg::NUM_ELEM]
);
	import mi3_pkg::*;

	rem_t sh;
	logic [NUM_ELEM-1:0] ge;

	assign sh = REM_W'(den) << BIT;

	always_comb begin
		for (int i = 0; i < NUM_ELEM; i++) begin
			ge[i] = (rem[i] >= sh);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	// one restoring quotient bit for all nine lanes
	always_ff @(posedge clk) begin
		ctl_s1 <= ctl;
		den_s1 <= den;
		for (int i = 0; i < NUM_ELEM; i++) begin
			rem_s1[i] <= ge[i] ? rem[i] - sh : rem[i];
			quo_s1[i] <= quo[i] | (DATA_W'(ge[i]) << BIT);
		end
	end

endmodule

>>> rtl/core/matrix3x3_inverse_core.sv
// start to done: adjugate, determinant, clamp check, divider steps, done register
// throughput: one item per cycle, busy is always low
// depth is set by the restoring divider, one quotient bit per stage for nine lanes
// the receiver cannot stall: each result is shown for exactly one cycle on done
// reset clears all valid bits, so no done is seen until a new item passes through
module matrix3x3_inverse_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mi3_pkg::mat_in_t  mat,
	output logic              done,
	output mi3_pkg::inv_out_t inv
);
	import mi3_pkg::*;

	localparam int LAT = DATA_W + 8;
	localparam quo_t HALF = quo_t'(1) << (DATA_W - 1);

	logic adj_vld;
	cof_t adj_cof [NUM_ELEM];
	elem_t adj_row0 [3];

	logic det_vld;
	sign_t det_sgn;
	rem_t det_num [NUM_ELEM];
	logic [DET_W-1:0] det_den;

	logic vld_s1;
	div_ctl_t ctl_s1;
	logic [DET_W-1:0] den_s1;
	rem_t num_s1 [NUM_ELEM];

	logic vld_c [DATA_W+1];
	div_ctl_t ctl_c [DATA_W+1];
	logic [DET_W-1:0] den_c [DATA_W+1];
	rem_t rem_c [DATA_W+1][NUM_ELEM];
	quo_t quo_c [DATA_W+1][NUM_ELEM];

	elem_t res [NUM_ELEM];
	logic [NUM_ELEM-1:0] over;
	quo_t lim [NUM_ELEM];
	quo_t val [NUM_ELEM];

	logic done_q;
	inv_out_t inv_q;

	// fully pipelined, never refuses an item
	assign busy = 1'b0;

	mi3_adj u_adj (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (start),
		.mat     (mat),
		.vld_s2  (adj_vld),
		.cof_s2  (adj_cof),
		.row0_s2 (adj_row0)
	);

	mi3_det #(.FRAC_BITS(FRAC_BITS)) u_det (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (adj_vld),
		.cof    (adj_cof),
		.row0   (adj_row0),
		.vld_s4 (det_vld),
		.sgn_s4 (det_sgn),
		.num_s4 (det_num),
		.den_s4 (det_den)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= det_vld;
		end
	end

	// quotient needs more than DATA_W bits: flag it so the result is clamped
	always_ff @(posedge clk) begin
		ctl_s1.sgn <= det_sgn;
		den_s1 <= det_den;
		for (int i = 0; i < NUM_ELEM; i++) begin
			ctl_s1.big[i] <= (det_num[i] >= (REM_W'(det_den) << DATA_W));
			num_s1[i] <= det_num[i];
		end
	end

	assign vld_c[0] = vld_s1;
	assign ctl_c[0] = ctl_s1;
	assign den_c[0] = den_s1;
	for (genvar i = 0; i < NUM_ELEM; i++) begin : g_seed
		assign rem_c[0][i] = num_s1[i];
		assign quo_c[0][i] = '0;
	end

	for (genvar k = 0; k < DATA_W; k++) begin : g_div
		mi3_div_step #(.BIT(DATA_W - 1 - k)) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.vld    (vld_c[k]),
			.ctl    (ctl_c[k]),
			.den    (den_c[k]),
			.rem    (rem_c[k]),
			.quo    (quo_c[k]),
			.vld_s1 (vld_c[k+1]),
			.ctl_s1 (ctl_c[k+1]),
			.den_s1 (den_c[k+1]),
			.rem_s1 (rem_c[k+1]),
			.quo_s1 (quo_c[k+1])
		);
	end

	always_comb begin
		for (int i = 0; i < NUM_ELEM; i++) begin
			lim[i]  = ctl_c[DATA_W].sgn.neg[i] ? HALF : HALF - quo_t'(1);
			over[i] = ctl_c[DATA_W].big[i] || (quo_c[DATA_W][i] > lim[i]);
			val[i]  = over[i] ? lim[i] : quo_c[DATA_W][i];
			if (ctl_c[DATA_W].sgn.singular) begin
				res[i] = '0;
			end else begin
				res[i] = ctl_c[DATA_W].sgn.neg[i] ? -val[i] : val[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_c[DATA_W];
		end
	end

	always_ff @(posedge clk) begin
		inv_q.r00 <= res[0];
		inv_q.r01 <= res[1];
		inv_q.r02 <= res[2];
		inv_q.r10 <= res[3];
		inv_q.r11 <= res[4];
		inv_q.r12 <= res[5];
		inv_q.r20 <= res[6];
		inv_q.r21 <= res[7];
		inv_q.r22 <= res[8];
		inv_q.singular  <= ctl_c[DATA_W].sgn.singular;
		inv_q.saturated <= (|over) && !ctl_c[DATA_W].sgn.singular;
	end

	assign done = done_q;
	assign inv  = inv_q;

	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a matching item");

	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("item lost in the pipeline");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && inv.singular |-> !inv.saturated && inv.r00 == '0 && inv.r11 == '0
			&& inv.r22 == '0 && inv.r01 == '0 && inv.r20 == '0)
		else $error("singular result not cleared");

endmodule

>>> tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mi3_pkg::*;

	localparam int FRAC = 16;
	localparam int LATENCY = DATA_W + 8;
	localparam int WATCHDOG_LIMIT = 20 * LATENCY + 2000;
	localparam int N_RANDOM = 1800;

	typedef logic signed [255:0] wide_t;

	// inverse by the adjugate at full width, truncated toward zero and clamped
	function automatic inv_out_t invert_matrix(input mat_in_t m);
		wide_t a [9];
		wide_t cof [9];
		wide_t det, num, q, mag_n, mag_d, lim;
		logic neg, sat;
		inv_out_t r;
		int i;
		a[0] = m.m00; a[1] = m.m01; a[2] = m.m02;
		a[3] = m.m10; a[4] = m.m11; a[5] = m.m12;
		a[6] = m.m20; a[7] = m.m21; a[8] = m.m22;
		cof[0] = a[4] * a[8] - a[7] * a[5];
		cof[1] = a[2] * a[7] - a[8] * a[1];
		cof[2] = a[1] * a[5] - a[4] * a[2];
		cof[3] = a[5] * a[6] - a[8] * a[3];
		cof[4] = a[0] * a[8] - a[6] * a[2];
		cof[5] = a[2] * a[3] - a[5] * a[0];
		cof[6] = a[3] * a[7] - a[6] * a[4];
		cof[7] = a[1] * a[6] - a[7] * a[0];
		cof[8] = a[0] * a[4] - a[3] * a[1];
		det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
		r = '0;
		if (det == 0) begin
			r.singular = 1'b1;
			return r;
		end
		sat = 1'b0;
		mag_d = (det < 0) ? -det : det;
		for (i = 0; i < 9; i++) begin
			neg = (cof[i] < 0) != (det < 0);
			num = (cof[i] < 0) ? -cof[i] : cof[i];
			mag_n = num <<< (2 * FRAC);
			q = mag_n / mag_d;
			lim = neg ? (wide_t'(1) <<< 31) : ((wide_t'(1) <<< 31) - 1);
			if (q > lim) begin
				q = lim;
				sat = 1'b1;
			end
			if (neg)
				q = -q;
			case (i)
				0: r.r00 = q[31:0];
				1: r.r01 = q[31:0];
				2: r.r02 = q[31:0];
				3: r.r10 = q[31:0];
				4: r.r11 = q[31:0];
				5: r.r12 = q[31:0];
				6: r.r20 = q[31:0];
				7: r.r21 = q[31:0];
				default: r.r22 = q[31:0];
			endcase
		end
		r.saturated = sat;
		return r;
	endfunction

	class inverse_scoreboard;
		inv_out_t pending_inverses [$];
		int errors;
		int mismatches;

		function void note_matrix(mat_in_t m);
			pending_inverses.push_back(invert_matrix(m));
		endfunction

		function void check_inverse(inv_out_t got);
			inv_out_t want;
			if (pending_inverses.size() == 0) begin
				errors++;
				$display("unexpected inverse %h", got);
				return;
			end
			want = pending_inverses.pop_front();
			if (got !== want) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("inverse mismatch: expected %h actual %h", want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	mat_in_t mat;
	logic done;
	inv_out_t inv;

	inverse_scoreboard sb;
	int sender_idle_pct;
	int idle_cycles;
	logic stim_done;

	matrix3x3_inverse_core #(.FRAC_BITS(FRAC)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mat(mat),
		.done(done),
		.inv(inv)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic elem_t rand_elem(input int kind);
		case (kind)
			0: return elem_t'($urandom());
			1: return elem_t'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
			2: return elem_t'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
			default: begin
				case ($urandom_range(0, 5))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return '0;
					3: return 32'sh0001_0000;
					4: return -32'sh0001_0000;
					default: return 32'sh0000_0001;
				endcase
			end
		endcase
	endfunction

	function automatic mat_in_t rand_matrix();
		mat_in_t m;
		elem_t e [9];
		int kind, i;
		kind = $urandom_range(0, 9);
		kind = (kind < 2) ? 0 : (kind < 6) ? 1 : (kind < 8) ? 2 : 3;
		for (i = 0; i < 9; i++)
			e[i] = rand_elem(kind);
		// some singular ones: repeat a row
		if ($urandom_range(0, 15) == 0) begin
			e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
		end
		m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
		return m;
	endfunction

	// start stays high between back to back items and drops only while idling
	task automatic send_matrix(input mat_in_t m);
		while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		mat <= m;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_matrix(m);
	endtask

	task automatic send_diag(input elem_t a, input elem_t b, input elem_t c);
		send_matrix({a, elem_t'(0), elem_t'(0), elem_t'(0), b, elem_t'(0),
			elem_t'(0), elem_t'(0), c});
	endtask

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_inverse(inv);
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else if (!stim_done)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int i, wait_cycles;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		mat = '0;
		idle_cycles = 0;
		stim_done = 1'b0;
		sender_idle_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: identity, scales, singular, extremes, rounding
		send_diag(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
		send_diag(32'sh0002_0000, -32'sh0004_0000, 32'sh0000_8000);
		send_diag(32'sh0000_0003, 32'sh0003_0000, -32'sh0003_0000);
		send_matrix('0);
		send_diag(32'sh0001_0000, 32'sh0000_0000, 32'sh0001_0000);
		send_diag(32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001);
		send_diag(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
		send_diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		send_diag(32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0001);
		send_diag(-32'sh0000_0001, 32'sh0000_0001, -32'sh0000_0001);
		send_matrix({9{32'sh7fff_ffff}});
		send_matrix({9{32'sh8000_0000}});
		send_matrix({9{32'shffff_ffff}});
		send_matrix({32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
			32'sh0000_0000, 32'sh0001_0000, 32'sh0004_0000,
			32'sh0005_0000, 32'sh0006_0000, 32'sh0000_0000});
		send_matrix({32'sh0002_0000, -32'sh0001_0000, 32'sh0000_0000,
			-32'sh0001_0000, 32'sh0002_0000, -32'sh0001_0000,
			32'sh0000_0000, -32'sh0001_0000, 32'sh0002_0000});
		send_matrix({32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
			32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
			32'sh0000_0001, -32'sh0000_0001, 32'sh5555_5555});

		for (i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3)
				sender_idle_pct = 73;
			else if (i == 2 * N_RANDOM / 3)
				sender_idle_pct = 0;
			else if (i == 0)
				sender_idle_pct = 32;
			send_matrix(rand_matrix());
		end
		start <= 1'b0;
		stim_done = 1'b1;

		wait_cycles = 0;
		while (sb.pending_inverses.size() != 0 && wait_cycles < 10 * LATENCY) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (LATENCY + 4) @(posedge clk);
		if (sb.errors == 0 && sb.pending_inverses.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> matrix3x3_inverse_core.f
rtl/core/mi3_pkg.sv
rtl/core/mi3_adj.sv
rtl/core/mi3_det.sv
rtl/core/mi3_div_step.sv
rtl/core/matrix3x3_inverse_core.sv
tb/testbench.sv
